>>> hw/rtl/skil_pkg.sv
// Shared types, codes and sizes for the sorted key index lookup block.
`default_nettype none

package skil_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 64;
    localparam int OFF_W    = 32;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_QUERY  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_FULL    = 2'd1;
    localparam logic [1:0] STATUS_NOMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] record_offset;
    } req_t;

    typedef struct packed {
        logic [OFF_W-1:0] hit_offset;
        logic [1:0]       status;
        logic             last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FLAGS,
        ST_SEARCH,
        ST_INSERT,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic             ins_en;
        logic [IDX_W-1:0] pos;
        logic [KEY_W-1:0] key;
        logic [OFF_W-1:0] offset;
        logic             key_signed;
        logic             by_offset;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/skil_cell.sv
// One table entry: holds a key and offset, compares them to the target, shifts on insert.
`default_nettype none

module skil_cell (
    input  wire logic                     clk,
    input  wire logic [skil_pkg::IDX_W-1:0] idx,
    input  wire skil_pkg::cell_cmd_t      cmd,
    input  wire logic [skil_pkg::KEY_W-1:0] prev_key,
    input  wire logic [skil_pkg::OFF_W-1:0] prev_offset,
    output logic [skil_pkg::KEY_W-1:0]    key,
    output logic [skil_pkg::OFF_W-1:0]    offset,
    output logic                          lt,
    output logic                          eq
);

    logic [skil_pkg::KEY_W-1:0] key_reg;
    logic [skil_pkg::KEY_W-1:0] key_next;
    logic [skil_pkg::OFF_W-1:0] offset_reg;
    logic [skil_pkg::OFF_W-1:0] offset_next;
    logic [skil_pkg::KEY_W-1:0] flip;
    logic [skil_pkg::KEY_W-1:0] entry_ord;
    logic [skil_pkg::KEY_W-1:0] target_ord;

    always_comb
    begin
        key_next    = key_reg;
        offset_next = offset_reg;
        if (cmd.ins_en)
        begin
            if (idx == cmd.pos)
            begin
                key_next    = cmd.key;
                offset_next = cmd.offset;
            end
            else if (idx > cmd.pos)
            begin
                key_next    = prev_key;
                offset_next = prev_offset;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        offset_reg <= offset_next;
    end

    // In signed mode, flip the sign bit so unsigned order gives signed order.
    assign flip       = {cmd.key_signed, {(skil_pkg::KEY_W-1){1'b0}}};
    assign entry_ord  = key_reg ^ flip;
    assign target_ord = cmd.key ^ flip;

    always_comb
    begin
        if (entry_ord != target_ord)
            lt = entry_ord < target_ord;
        else
            lt = cmd.by_offset && (offset_reg <= cmd.offset);
    end

    assign eq     = (key_reg == cmd.key);
    assign key    = key_reg;
    assign offset = offset_reg;

endmodule

`default_nettype wire

>>> hw/rtl/skil_seq.sv
// Sequencer: handshakes, binary search over cell flags, insert control and result emission.
`default_nettype none

module skil_seq (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire skil_pkg::req_t              req,
    output logic                             rsp_valid,
    input  wire logic                        rsp_ready,
    output skil_pkg::rsp_t                   rsp,
    input  wire logic                        cfg_wen,
    input  wire logic                        cfg_wdata,
    output skil_pkg::cell_cmd_t              cmd,
    input  wire logic [skil_pkg::CAPACITY-1:0] lt_vec,
    input  wire logic [skil_pkg::CAPACITY-1:0] eq_vec,
    output logic [skil_pkg::IDX_W-1:0]       rd_idx,
    input  wire logic [skil_pkg::OFF_W-1:0]  rd_offset
);

    localparam logic [skil_pkg::CNT_W-1:0] CAP_CNT = skil_pkg::CNT_W'(skil_pkg::CAPACITY);

    skil_pkg::state_t state_reg;
    skil_pkg::state_t state_next;

    logic [1:0]                    func_reg;
    logic [1:0]                    func_next;
    logic [skil_pkg::KEY_W-1:0]    key_reg;
    logic [skil_pkg::KEY_W-1:0]    key_next;
    logic [skil_pkg::OFF_W-1:0]    off_reg;
    logic [skil_pkg::OFF_W-1:0]    off_next;
    logic [skil_pkg::CNT_W-1:0]    lo_reg;
    logic [skil_pkg::CNT_W-1:0]    lo_next;
    logic [skil_pkg::CNT_W-1:0]    hi_reg;
    logic [skil_pkg::CNT_W-1:0]    hi_next;
    logic [skil_pkg::CNT_W-1:0]    count_reg;
    logic [skil_pkg::CNT_W-1:0]    count_next;
    logic [skil_pkg::CAPACITY-1:0] lt_reg;
    logic [skil_pkg::CAPACITY-1:0] lt_next;
    logic [skil_pkg::CAPACITY-1:0] eq_reg;
    logic [skil_pkg::CAPACITY-1:0] eq_next;
    logic [1:0]                    status_reg;
    logic [1:0]                    status_next;
    logic                          ks_reg;
    logic                          ks_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    skil_pkg::rsp_t                rsp_reg;
    skil_pkg::rsp_t                rsp_next;

    logic                          accept;
    logic                          slot_free;
    logic                          search_on;
    logic [skil_pkg::CNT_W-1:0]    mid;
    logic [skil_pkg::CNT_W-1:0]    nxt;
    logic                          hit;
    logic                          more;

    assign req_ready = (state_reg == skil_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign search_on = (lo_reg < hi_reg);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign nxt       = lo_reg + 1'b1;
    assign hit       = (lo_reg < count_reg) && eq_reg[lo_reg[skil_pkg::IDX_W-1:0]];
    assign more      = (nxt < count_reg) && eq_reg[nxt[skil_pkg::IDX_W-1:0]];
    assign rd_idx    = lo_reg[skil_pkg::IDX_W-1:0];

    always_comb
    begin
        cmd.ins_en     = (state_reg == skil_pkg::ST_INSERT);
        cmd.pos        = lo_reg[skil_pkg::IDX_W-1:0];
        cmd.key        = key_reg;
        cmd.offset     = off_reg;
        cmd.key_signed = ks_reg;
        cmd.by_offset  = (func_reg == skil_pkg::FUNC_INSERT);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skil_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.func)
                        skil_pkg::FUNC_INSERT:
                            state_next = (count_reg >= CAP_CNT) ? skil_pkg::ST_RESP
                                                                : skil_pkg::ST_FLAGS;
                        skil_pkg::FUNC_QUERY: state_next = skil_pkg::ST_FLAGS;
                        skil_pkg::FUNC_CLEAR: state_next = skil_pkg::ST_RESP;
                        default:              state_next = skil_pkg::ST_IDLE;
                    endcase
                end
            end
            skil_pkg::ST_FLAGS:  state_next = skil_pkg::ST_SEARCH;
            skil_pkg::ST_SEARCH:
            begin
                if (!search_on)
                    state_next = (func_reg == skil_pkg::FUNC_INSERT) ? skil_pkg::ST_INSERT
                                                                      : skil_pkg::ST_SCAN;
            end
            skil_pkg::ST_INSERT: state_next = skil_pkg::ST_RESP;
            skil_pkg::ST_RESP:
            begin
                if (slot_free)
                    state_next = skil_pkg::ST_IDLE;
            end
            skil_pkg::ST_SCAN:
            begin
                if (slot_free && (!hit || !more))
                    state_next = skil_pkg::ST_IDLE;
            end
            default: state_next = skil_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        func_next      = func_reg;
        key_next       = key_reg;
        off_next       = off_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        count_next     = count_reg;
        lt_next        = lt_reg;
        eq_next        = eq_reg;
        status_next    = status_reg;
        ks_next        = cfg_wen ? cfg_wdata : ks_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            skil_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next   = req.func;
                    key_next    = req.key;
                    off_next    = req.record_offset;
                    lo_next     = '0;
                    hi_next     = count_reg;
                    status_next = skil_pkg::STATUS_OK;
                    if (req.func == skil_pkg::FUNC_INSERT && count_reg >= CAP_CNT)
                        status_next = skil_pkg::STATUS_FULL;
                    if (req.func == skil_pkg::FUNC_CLEAR)
                        count_next = '0;
                end
            end
            skil_pkg::ST_FLAGS:
            begin
                lt_next = lt_vec;
                eq_next = eq_vec;
            end
            skil_pkg::ST_SEARCH:
            begin
                if (search_on)
                begin
                    if (lt_reg[mid[skil_pkg::IDX_W-1:0]])
                        lo_next = mid + 1'b1;
                    else
                        hi_next = mid;
                end
            end
            skil_pkg::ST_INSERT:
            begin
                count_next  = count_reg + 1'b1;
                status_next = skil_pkg::STATUS_OK;
            end
            skil_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.hit_offset = '0;
                    rsp_next.status     = status_reg;
                    rsp_next.last       = 1'b1;
                end
            end
            skil_pkg::ST_SCAN:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    if (hit)
                    begin
                        rsp_next.hit_offset = rd_offset;
                        rsp_next.status     = skil_pkg::STATUS_OK;
                        rsp_next.last       = !more;
                        lo_next             = nxt;
                    end
                    else
                    begin
                        rsp_next.hit_offset = '0;
                        rsp_next.status     = skil_pkg::STATUS_NOMATCH;
                        rsp_next.last       = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= skil_pkg::ST_IDLE;
            count_reg     <= '0;
            ks_reg        <= 1'b1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ks_reg        <= ks_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        off_reg    <= off_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        lt_reg     <= lt_next;
        eq_reg     <= eq_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sorted_key_index_lookup.sv
// Insert: flag capture, one binary-search probe per halving (up to 6 probes), shift.
// Query: flag capture, up to 7 probes, then one result per cycle per matching entry
// (or one no-match result) unless the output stalls. Clear and full insert respond
// directly. One item at a time; the probe loop and the scan set the rate. The result
// register lets the next item start while a final result still waits. Reset (rst_n,
// async low) empties the table and sets signed key compare; entries are not cleared.
`default_nettype none

module sorted_key_index_lookup (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire skil_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output skil_pkg::rsp_t      rsp,
    input  wire logic           cfg_wen,
    input  wire logic           cfg_wdata
);

    skil_pkg::cell_cmd_t               cmd;
    logic [skil_pkg::CAPACITY-1:0]     lt_vec;
    logic [skil_pkg::CAPACITY-1:0]     eq_vec;
    logic [skil_pkg::IDX_W-1:0]        rd_idx;
    logic [skil_pkg::OFF_W-1:0]        rd_offset;
    logic [skil_pkg::KEY_W-1:0]        cell_key [skil_pkg::CAPACITY];
    logic [skil_pkg::OFF_W-1:0]        cell_off [skil_pkg::CAPACITY];

    for (genvar i = 0; i < skil_pkg::CAPACITY; i++)
    begin : g_cell
        logic [skil_pkg::KEY_W-1:0] prev_key;
        logic [skil_pkg::OFF_W-1:0] prev_off;

        if (i == 0)
        begin : g_head
            assign prev_key = '0;
            assign prev_off = '0;
        end
        else
        begin : g_link
            assign prev_key = cell_key[i-1];
            assign prev_off = cell_off[i-1];
        end

        skil_cell u_cell (
            .clk         (clk),
            .idx         (skil_pkg::IDX_W'(i)),
            .cmd         (cmd),
            .prev_key    (prev_key),
            .prev_offset (prev_off),
            .key         (cell_key[i]),
            .offset      (cell_off[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    // Select the offset of the scanned entry.
    always_comb
    begin
        rd_offset = '0;
        for (int i = 0; i < skil_pkg::CAPACITY; i++)
        begin
            if (rd_idx == skil_pkg::IDX_W'(i))
                rd_offset = rd_offset | cell_off[i];
        end
    end

    skil_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .lt_vec    (lt_vec),
        .eq_vec    (eq_vec),
        .rd_idx    (rd_idx),
        .rd_offset (rd_offset)
    );

endmodule

`default_nettype wire
